/* hw/rtl/anf_pkg.sv */
// Shared types and constants for the ANF polynomial evaluator.
`default_nettype none

package anf_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned OnesW   = 24;
  localparam int unsigned StoredW = 13;
  localparam logic [OnesW-1:0] OnesMax = '1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_EVAL   = 2'd2
  } anf_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH,
    ST_RESP
  } anf_state_e;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
  } anf_cmd_t;

  typedef struct packed {
    logic is_eval;
    logic empty;
    logic addr_last;
  } anf_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/anf_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module anf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/anf_ctrl.sv */
// Controller state machine: sequences accept, store walk, commit and result beat.
`default_nettype none

module anf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire anf_pkg::anf_sts_t sts_i,
  output anf_pkg::anf_cmd_t      cmd_o
);
  import anf_pkg::*;

  anf_state_e state_q, state_d;

  // Decode of the accepted op is visible in the cycle after load.
  logic pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_FINISH;
        end
      end
      ST_WALK: begin
        if (sts_i.addr_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: begin
        if (pending_q && sts_i.is_eval && !sts_i.empty) begin
          state_d = ST_WALK;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else begin
      pending_q <= in_valid_i && (state_q == ST_IDLE);
    end
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_WALK:   cmd_o.rd_en = 1'b1;
      ST_DRAIN:  cmd_o = '0;
      ST_FINISH: cmd_o.commit = !(pending_q && sts_i.is_eval && !sts_i.empty);
      ST_RESP:   out_valid_o = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/anf_dp.sv */
// Datapath: op and key registers, monomial store, walk counter, parity and counts.
`default_nettype none

module anf_dp #(
  parameter int unsigned MaxTerms = 4096,
  parameter int unsigned KeyBits  = 128
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [1:0]                      operation_i,
  input  wire logic [anf_pkg::WordW-1:0]       word_low_i,
  input  wire logic [anf_pkg::WordW-1:0]       word_high_i,
  input  wire anf_pkg::anf_cmd_t               cmd_i,
  output anf_pkg::anf_sts_t                    sts_o,
  output logic                                 poly_value_o,
  output logic [anf_pkg::OnesW-1:0]            ones_total_o,
  output logic [anf_pkg::StoredW-1:0]          stored_terms_o,
  output logic                                 store_overflow_o
);
  import anf_pkg::*;

  localparam int unsigned AddrW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int unsigned CntW  = $clog2(MaxTerms + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxTerms);

  logic [1:0]         op_q;
  logic [KeyBits-1:0] key_q;
  logic [AddrW-1:0]   addr_q;
  logic               rd_valid_q;
  logic               parity_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [OnesW-1:0]   ones_q, ones_d;
  logic               poly_q, overflow_q;
  logic [KeyBits-1:0] rd_data;
  logic               full, match, ram_we;

  logic [2*WordW-1:0] word_in;
  assign word_in = {word_high_i, word_low_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= OP_CLEAR;
      rd_valid_q <= 1'b0;
      parity_q   <= 1'b0;
      addr_q     <= '0;
      count_q    <= '0;
      ones_q     <= '0;
      poly_q     <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.rd_en;
      if (cmd_i.load) begin
        op_q     <= operation_i;
        addr_q   <= '0;
        parity_q <= 1'b0;
      end else begin
        if (cmd_i.rd_en) begin
          addr_q <= addr_q + AddrW'(1);
        end
        if (rd_valid_q && match) begin
          parity_q <= !parity_q;
        end
      end
      if (cmd_i.commit) begin
        count_q    <= count_d;
        ones_q     <= ones_d;
        poly_q     <= (op_q == OP_EVAL) && parity_q;
        overflow_q <= (op_q == OP_APPEND) && full;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= word_in[KeyBits-1:0];
    end
  end

  assign full  = (count_q == CntMax);
  assign match = ((rd_data & key_q) == rd_data);

  always_comb begin
    count_d = count_q;
    ones_d  = ones_q;
    ram_we  = 1'b0;
    unique case (op_q)
      OP_CLEAR: begin
        count_d = '0;
        ones_d  = '0;
      end
      OP_APPEND: begin
        if (!full) begin
          count_d = count_q + CntW'(1);
          ram_we  = cmd_i.commit;
        end
      end
      OP_EVAL: begin
        if (parity_q && (ones_q != OnesMax)) begin
          ones_d = ones_q + OnesW'(1);
        end
      end
      default: count_d = count_q;
    endcase
  end

  anf_ram #(
    .Width (KeyBits),
    .Depth (MaxTerms)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (key_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  assign sts_o.is_eval   = (op_q == OP_EVAL);
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.addr_last = (CntW'(addr_q) == (count_q - CntW'(1)));

  assign poly_value_o     = poly_q;
  assign ones_total_o     = ones_q;
  assign stored_terms_o   = StoredW'(count_q);
  assign store_overflow_o = overflow_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, count_q} <= {1'b0, CntMax})
    else $error("term count beyond store depth");

  a_ones_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.commit && (op_q == OP_CLEAR)) |=> ones_q >= $past(ones_q))
    else $error("ones counter dropped without clear");

  a_ovf_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |-> full)
    else $error("overflow flag without a full store");

  a_poly_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poly_q |-> (ones_q != '0))
    else $error("polynomial value set with a zero ones count");

endmodule

`default_nettype wire

/* hw/rtl/anf_polynomial_evaluator_core.sv */
// Top level of the ANF polynomial evaluator: controller plus datapath.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | operation_i, word_low_i, word_high_i
//   out     | output    | out_valid_o/out_ready_i | poly_value_o, ones_total_o,
//           |           |                         | stored_terms_o, store_overflow_o
//
// Clear, append, unused codes and evaluate of an empty store: accept in
// IDLE, commit in FINISH, result beat in RESP. Evaluate of a non-empty
// store adds a WALK with one read per held monomial through the single RAM
// read port, plus decode, read drain and commit. One item is in flight at a
// time; in_ready_o is low until the cycle after the result beat is taken, so
// a new item cannot start before the last result beat is taken.
// Reset empties the store count and zeroes the ones counter; the store itself
// needs no clearing pass.
`default_nettype none

module anf_polynomial_evaluator_core #(
  parameter int unsigned MAX_TERMS = 4096,
  parameter int unsigned KEY_BITS  = 128
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [1:0]                 operation_i,
  input  wire logic [anf_pkg::WordW-1:0]  word_low_i,
  input  wire logic [anf_pkg::WordW-1:0]  word_high_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            poly_value_o,
  output logic [anf_pkg::OnesW-1:0]       ones_total_o,
  output logic [anf_pkg::StoredW-1:0]     stored_terms_o,
  output logic                            store_overflow_o
);
  import anf_pkg::*;

  anf_cmd_t cmd;
  anf_sts_t sts;

  anf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  anf_dp #(
    .MaxTerms (MAX_TERMS),
    .KeyBits  (KEY_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .operation_i      (operation_i),
    .word_low_i       (word_low_i),
    .word_high_i      (word_high_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .poly_value_o     (poly_value_o),
    .ones_total_o     (ones_total_o),
    .stored_terms_o   (stored_terms_o),
    .store_overflow_o (store_overflow_o)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the ANF polynomial evaluator core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import anf_pkg::*;

  localparam int unsigned MaxTerms   = 4096;
  localparam int unsigned KeyBits    = 128;
  localparam logic [127:0] KeyMask   =
    (KeyBits >= 128) ? '1 : ((128'(1) << KeyBits) - 128'(1));
  localparam logic [1:0] OpUnused    = 2'd3;
  localparam int unsigned CycleLimit = 1000000;

  typedef struct {
    logic               poly_value;
    logic [OnesW-1:0]   ones_total;
    logic [StoredW-1:0] stored_terms;
    logic               store_overflow;
  } anf_outcome_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [1:0]         op_r       = OP_CLEAR;
  logic [WordW-1:0]   word_low   = '0;
  logic [WordW-1:0]   word_high  = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic               poly_value;
  logic [OnesW-1:0]   ones_total;
  logic [StoredW-1:0] stored_terms;
  logic               store_overflow;

  logic [127:0]       term_store [MaxTerms];
  int unsigned        term_cnt = 0;
  logic [OnesW-1:0]   ones_cnt = '0;
  anf_outcome_t       outcome_q [$];

  int unsigned        err_count     = 0;
  int unsigned        cycle_count   = 0;
  bit                 no_idle       = 1'b0;
  int unsigned        hold_request  = 0;

  anf_polynomial_evaluator_core #(
    .MAX_TERMS(MaxTerms),
    .KEY_BITS (KeyBits)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .operation_i     (op_r),
    .word_low_i      (word_low),
    .word_high_i     (word_high),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .poly_value_o    (poly_value),
    .ones_total_o    (ones_total),
    .stored_terms_o  (stored_terms),
    .store_overflow_o(store_overflow)
  );

  always #6 clk = ~clk;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] sparse64();
    return rand64() & rand64() & rand64();
  endfunction

  task automatic apply_anf_item(input logic [1:0] op, input logic [63:0] lo,
                                input logic [63:0] hi);
    logic [127:0] key;
    logic         parity;
    anf_outcome_t res;
    key = {hi, lo} & KeyMask;
    parity = 1'b0;
    res.poly_value = 1'b0;
    res.store_overflow = 1'b0;
    case (op)
      OP_CLEAR: begin
        term_cnt = 0;
        ones_cnt = '0;
      end
      OP_APPEND: begin
        if (term_cnt < MaxTerms) begin
          term_store[term_cnt] = key;
          term_cnt++;
        end else begin
          res.store_overflow = 1'b1;
        end
      end
      OP_EVAL: begin
        for (int unsigned i = 0; i < term_cnt; i++) begin
          if ((term_store[i] & key) == term_store[i]) parity = ~parity;
        end
        res.poly_value = parity;
        if (parity && ones_cnt != OnesMax) ones_cnt++;
      end
      default: ;
    endcase
    res.ones_total = ones_cnt;
    res.stored_terms = StoredW'(term_cnt);
    outcome_q.push_back(res);
  endtask

  // Call at a rising edge; returns at the edge where the beat is taken.
  task automatic send_item(input logic [1:0] op, input logic [63:0] lo,
                           input logic [63:0] hi);
    int unsigned gap;
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op_r      <= op;
    word_low  <= lo;
    word_high <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_anf_item(op, lo, hi);
  endtask

  task automatic send_term(input logic [1:0] op, input logic [127:0] w);
    send_item(op, w[63:0], w[127:64]);
  endtask

  task automatic test_reset_state();
    send_term(OP_EVAL, {rand64(), rand64()});
    send_term(OpUnused, {rand64(), rand64()});
    send_term(OP_CLEAR, '0);
  endtask

  task automatic test_directed_terms();
    send_term(OP_APPEND, '0);
    send_term(OP_EVAL, '0);
    send_term(OP_APPEND, 128'(1));
    send_term(OP_APPEND, 128'(1) << 63);
    send_term(OP_APPEND, 128'(1) << 64);
    send_term(OP_APPEND, 128'(1) << 127);
    send_term(OP_APPEND, '1);
    send_term(OP_EVAL, '0);
    send_term(OP_EVAL, 128'(1));
    send_term(OP_EVAL, (128'(1) << 63) | (128'(1) << 127));
    send_term(OP_EVAL, '1);
    send_term(OP_EVAL, 128'(1) << 64);
    send_term(OpUnused, '1);
    send_term(OpUnused, '0);
    send_term(OP_CLEAR, '1);
    send_term(OP_EVAL, '1);
    send_term(OP_APPEND, '1);
    send_term(OP_EVAL, '1);
  endtask

  task automatic test_output_backpressure();
    no_idle = 1'b1;
    hold_request = 200;
    send_term(OP_APPEND, {sparse64(), sparse64()});
    send_term(OP_EVAL, '1);
    send_term(OP_APPEND, 128'(1) << 100);
    send_term(OP_EVAL, {rand64(), rand64()});
    send_term(OpUnused, '0);
    send_term(OP_EVAL, '0);
    no_idle = 1'b0;
  endtask

  task automatic test_random_mix();
    int unsigned  r;
    logic [127:0] w;
    for (int unsigned n = 0; n < 110; n++) begin
      no_idle = (n >= 50 && n < 75);
      r = $urandom_range(0, 99);
      if (r < 6 || term_cnt > 48) begin
        send_term(OP_CLEAR, {rand64(), rand64()});
      end else if (r < 46) begin
        case ($urandom_range(0, 3))
          0, 1:    w = {sparse64(), sparse64()};
          2:       w = {rand64(), rand64()};
          default: w = 128'(1) << $urandom_range(0, 127);
        endcase
        send_term(OP_APPEND, w);
      end else if (r < 92) begin
        if (term_cnt > 0 && $urandom_range(0, 2) != 0) begin
          w = term_store[$urandom_range(0, term_cnt - 1)] | {sparse64(), sparse64()};
          if ($urandom_range(0, 1) == 1) w |= term_store[$urandom_range(0, term_cnt - 1)];
        end else begin
          w = {rand64() | rand64(), rand64() | rand64()};
        end
        send_term(OP_EVAL, w);
      end else begin
        send_term(OpUnused, {rand64(), rand64()});
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : main
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed_terms();
    test_output_backpressure();
    test_random_mix();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned stall_left;
    int unsigned idle_left;
    stall_left = 0;
    idle_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) idle_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    anf_outcome_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        $error("result beat with no pending item");
        err_count++;
      end else begin
        exp_res = outcome_q.pop_front();
        if (poly_value !== exp_res.poly_value) begin
          $error("poly_value: expected %0d, got %0d", exp_res.poly_value, poly_value);
          err_count++;
        end
        if (ones_total !== exp_res.ones_total) begin
          $error("ones_total: expected %0d, got %0d", exp_res.ones_total, ones_total);
          err_count++;
        end
        if (stored_terms !== exp_res.stored_terms) begin
          $error("stored_terms: expected %0d, got %0d", exp_res.stored_terms,
                 stored_terms);
          err_count++;
        end
        if (store_overflow !== exp_res.store_overflow) begin
          $error("store_overflow: expected %0d, got %0d", exp_res.store_overflow,
                 store_overflow);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

endmodule

/* anf_polynomial_evaluator_core.f */
hw/rtl/anf_pkg.sv
hw/rtl/anf_ram.sv
hw/rtl/anf_ctrl.sv
hw/rtl/anf_dp.sv
hw/rtl/anf_polynomial_evaluator_core.sv
sim/testbench.sv
